// File: rtl/core/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants for pixel extreme statistics
// Beat structs for pixels, queued work and results, stat ids, register
// indexes and the per-statistic helper functions.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int NUM_STATS = 8;
  localparam int STAT_W    = 3;
  localparam int COLOUR_W  = 8;
  localparam int POS_W     = 12;
  localparam int VALUE_W   = 10;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // statistic ids
  localparam logic [STAT_W-1:0] STAT_MAX_SUM = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MIN_SUM = 3'd1;
  localparam logic [STAT_W-1:0] STAT_MAX_R   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_MAX_G   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_MAX_B   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_MIN_R   = 3'd5;
  localparam logic [STAT_W-1:0] STAT_MIN_G   = 3'd6;
  localparam logic [STAT_W-1:0] STAT_MIN_B   = 3'd7;
  localparam logic [STAT_W-1:0] STAT_LAST    = STAT_MIN_B;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } pes_pixel_t;

  typedef struct packed {
    pes_pixel_t       pix;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             frame_end;
  } pes_work_t;

  typedef struct packed {
    logic [STAT_W-1:0]   stat_id;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [COLOUR_W-1:0] pixel_red;
    logic [COLOUR_W-1:0] pixel_green;
    logic [COLOUR_W-1:0] pixel_blue;
    logic [VALUE_W-1:0]  extreme_value;
    logic                last_of_run;
  } pes_result_t;

  // true for trackers that keep the largest value
  function automatic logic tracks_max(logic [STAT_W-1:0] id);
    return (id == STAT_MAX_SUM) || (id == STAT_MAX_R) ||
           (id == STAT_MAX_G) || (id == STAT_MAX_B);
  endfunction

  // value a tracker compares for one pixel
  function automatic logic [VALUE_W-1:0] stat_value(logic [STAT_W-1:0] id, pes_pixel_t pix);
    logic [VALUE_W-1:0] v;
    unique case (id)
      STAT_MAX_SUM, STAT_MIN_SUM: begin
        v = VALUE_W'(pix.red) + VALUE_W'(pix.green) + VALUE_W'(pix.blue);
      end
      STAT_MAX_R, STAT_MIN_R: v = VALUE_W'(pix.red);
      STAT_MAX_G, STAT_MIN_G: v = VALUE_W'(pix.green);
      default:                v = VALUE_W'(pix.blue);
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/pes_front.sv
// ----------------------------------------------------------------------------
// pes_front: pixel intake and raster position tracking
// Holds the geometry registers, counts column and row, and tags each
// pixel with its position and an end-of-frame mark for the back part.
// ----------------------------------------------------------------------------
module pes_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel beats
  input  logic                             in_push,
  input  pes_pkg::pes_pixel_t              in_data,
  output logic                             in_full,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pes_pkg::CFG_W-1:0]        cfg_data,
  // work queue
  output logic                             q_push,
  output pes_pkg::pes_work_t               q_data,
  input  logic                             q_full
);

  localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WX   = ($clog2(MAX_WIDTH + 1) > pes_pkg::CFG_W) ?
                        $clog2(MAX_WIDTH + 1) : pes_pkg::CFG_W;
  localparam int WY   = ($clog2(MAX_HEIGHT + 1) > pes_pkg::CFG_W) ?
                        $clog2(MAX_HEIGHT + 1) : pes_pkg::CFG_W;

  logic [pes_pkg::CFG_W-1:0] frame_width_r, frame_height_r;
  logic [XW-1:0]             col_r, col_nxt;
  logic [YW-1:0]             row_r, row_nxt;
  logic [WX-1:0]             eff_w, col_inc;
  logic [WY-1:0]             eff_h, row_inc;
  logic                      row_end, frame_end, accept;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  // effective geometry: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = WX'(1);
    end else if (WX'(frame_width_r) > WX'(MAX_WIDTH)) begin
      eff_w = WX'(MAX_WIDTH);
    end else begin
      eff_w = WX'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      eff_h = WY'(1);
    end else if (WY'(frame_height_r) > WY'(MAX_HEIGHT)) begin
      eff_h = WY'(MAX_HEIGHT);
    end else begin
      eff_h = WY'(frame_height_r);
    end
  end

  // raster position advance
  always_comb begin
    col_inc   = WX'(col_r) + WX'(1);
    row_inc   = WY'(row_r) + WY'(1);
    row_end   = (col_inc >= eff_w);
    frame_end = row_end && (row_inc >= eff_h);
    col_nxt   = row_end ? '0 : XW'(col_inc);
    if (!row_end) begin
      row_nxt = row_r;
    end else if (frame_end) begin
      row_nxt = '0;
    end else begin
      row_nxt = YW'(row_inc);
    end
  end

  // work beat to the queue
  assign q_push            = accept;
  assign q_data.pix        = in_data;
  assign q_data.pos_x      = pes_pkg::POS_W'(col_r);
  assign q_data.pos_y      = pes_pkg::POS_W'(row_r);
  assign q_data.frame_end  = frame_end;

  // geometry registers and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= pes_pkg::FRAME_WIDTH_RST;
      frame_height_r <= pes_pkg::FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == pes_pkg::REG_FRAME_WIDTH) begin
          frame_width_r <= cfg_data;
        end else if (cfg_index == pes_pkg::REG_FRAME_HEIGHT) begin
          frame_height_r <= cfg_data;
        end
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

// File: rtl/core/pes_queue.sv
// ----------------------------------------------------------------------------
// pes_queue: two-entry work queue between front and back
// Lets the front keep taking pixels while the back waits on result drain.
// ----------------------------------------------------------------------------
module pes_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  pes_pkg::pes_work_t wr_data,
  output logic               full,
  output logic               rd_valid,
  input  logic               rd_en,
  output pes_pkg::pes_work_t rd_data
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  pes_pkg::pes_work_t mem_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [AW:0]        count_r;
  logic               do_wr, do_rd;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + (AW+1)'(1);
        2'b01:   count_r <= count_r - (AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("work queue count beyond depth");

endmodule

// File: rtl/core/pes_back.sv
// ----------------------------------------------------------------------------
// pes_back: extreme trackers and result drain
// Eight trackers compare each pixel in parallel; at frame end the final
// extremes move to a snapshot bank that drains one result beat per pop.
// ----------------------------------------------------------------------------
module pes_back (
  input  logic                clk,
  input  logic                rst_n,
  // work queue
  input  logic                q_valid,
  input  pes_pkg::pes_work_t  q_data,
  output logic                q_pop,
  // result beats
  output logic                out_empty,
  input  logic                out_pop,
  output pes_pkg::pes_result_t out_data
);

  localparam int N = pes_pkg::NUM_STATS;

  logic [pes_pkg::VALUE_W-1:0] best_val_r [N];
  logic [pes_pkg::POS_W-1:0]   best_x_r   [N];
  logic [pes_pkg::POS_W-1:0]   best_y_r   [N];
  pes_pkg::pes_pixel_t         best_pix_r [N];
  logic [N-1:0]                seen_r;

  logic [pes_pkg::VALUE_W-1:0] snap_val_r [N];
  logic [pes_pkg::POS_W-1:0]   snap_x_r   [N];
  logic [pes_pkg::POS_W-1:0]   snap_y_r   [N];
  pes_pkg::pes_pixel_t         snap_pix_r [N];

  logic [pes_pkg::VALUE_W-1:0] cur_val [N];
  logic [N-1:0]                take;
  logic                        drain_r;
  logic [pes_pkg::STAT_W-1:0]  idx_r;
  logic                        drain_free, accept, pop_ok, start;

  // a frame end waits until the snapshot bank has drained
  assign pop_ok     = out_pop && drain_r;
  assign drain_free = !drain_r || (pop_ok && (idx_r == pes_pkg::STAT_LAST));
  assign q_pop      = q_valid && (!q_data.frame_end || drain_free);
  assign accept     = q_pop;
  assign start      = accept && q_data.frame_end;

  // per-tracker compare, strict so the earliest pixel keeps a tie
  always_comb begin
    for (int k = 0; k < N; k++) begin
      cur_val[k] = pes_pkg::stat_value(pes_pkg::STAT_W'(k), q_data.pix);
      if (!seen_r[k]) begin
        take[k] = 1'b1;
      end else if (pes_pkg::tracks_max(pes_pkg::STAT_W'(k))) begin
        take[k] = cur_val[k] > best_val_r[k];
      end else begin
        take[k] = cur_val[k] < best_val_r[k];
      end
    end
  end

  // tracker and snapshot payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (accept && take[k]) begin
        best_val_r[k] <= cur_val[k];
        best_x_r[k]   <= q_data.pos_x;
        best_y_r[k]   <= q_data.pos_y;
        best_pix_r[k] <= q_data.pix;
      end
      if (start) begin
        snap_val_r[k] <= take[k] ? cur_val[k]   : best_val_r[k];
        snap_x_r[k]   <= take[k] ? q_data.pos_x : best_x_r[k];
        snap_y_r[k]   <= take[k] ? q_data.pos_y : best_y_r[k];
        snap_pix_r[k] <= take[k] ? q_data.pix   : best_pix_r[k];
      end
    end
  end

  // seen flags and drain control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      drain_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (accept) begin
        seen_r <= q_data.frame_end ? '0 : (seen_r | take);
      end
      if (start) begin
        drain_r <= 1'b1;
        idx_r   <= '0;
      end else if (pop_ok) begin
        if (idx_r == pes_pkg::STAT_LAST) begin
          drain_r <= 1'b0;
        end
        idx_r <= idx_r + pes_pkg::STAT_W'(1);
      end
    end
  end

  // result beat from the snapshot bank
  always_comb begin
    out_empty              = !drain_r;
    out_data.stat_id       = idx_r;
    out_data.pos_x         = snap_x_r[idx_r];
    out_data.pos_y         = snap_y_r[idx_r];
    out_data.pixel_red     = snap_pix_r[idx_r].red;
    out_data.pixel_green   = snap_pix_r[idx_r].green;
    out_data.pixel_blue    = snap_pix_r[idx_r].blue;
    out_data.extreme_value = snap_val_r[idx_r];
    out_data.last_of_run   = (idx_r == pes_pkg::STAT_LAST);
  end

  a_start_drains: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> drain_r && (idx_r == '0))
    else $error("frame end did not open a result drain");

  a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r && !(pop_ok && (idx_r == pes_pkg::STAT_LAST)) |=> drain_r)
    else $error("result drain ended early");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r && !out_pop && !start |=> $stable(idx_r))
    else $error("result index moved without a pop");

endmodule

// File: rtl/core/pixel_extreme_statistics_top.sv
// ----------------------------------------------------------------------------
// pixel_extreme_statistics_top: per-frame RGB extreme search
// Tracks brightest/darkest pixel and min/max of each colour over a raster
// frame and reports eight result beats after the frame's last pixel.
//
//   channel  ports                               direction
//   in       in_push, in_data, in_full           pixel beats in
//   out      out_empty, out_pop, out_data        result beats out
//   cfg      cfg_valid, cfg_ready, cfg_index,    register writes in
//            cfg_data
//
// One pixel beat per clock while in_full is low; the tracker compares
// finish in the cycle a beat leaves the work queue, so results are
// registered in the snapshot bank after the frame's last pixel leaves the
// queue, and drain one beat per clock while out_pop is held. A new frame
// end waits at the head of the work queue until the eight results of the
// previous frame are popped; once the queue behind it fills, in_full
// holds off further pixels. Reset is synchronous, with no clearing pass.
// ----------------------------------------------------------------------------
module pixel_extreme_statistics_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  pes_pkg::pes_pixel_t           in_data,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output pes_pkg::pes_result_t          out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pes_pkg::CFG_W-1:0]     cfg_data
);

  logic               fq_push, fq_full, qb_valid, qb_pop;
  pes_pkg::pes_work_t fq_data, qb_data;

  // intake and position tagging
  pes_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (fq_push),
    .q_data    (fq_data),
    .q_full    (fq_full)
  );

  // decoupling queue
  pes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fq_push),
    .wr_data  (fq_data),
    .full     (fq_full),
    .rd_valid (qb_valid),
    .rd_en    (qb_pop),
    .rd_data  (qb_data)
  );

  // trackers and result drain
  pes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_data    (qb_data),
    .q_pop     (qb_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: bench/pes_result_checker.sv
// ----------------------------------------------------------------------------
// pes_result_checker: scoreboard for pixel extreme statistics
// Watches the pixel, result and register channels of the block, keeps its
// own copy of frame geometry and the eight running extremes, queues the
// eight result beats due at each frame end and compares every popped beat
// field by field against the oldest one still due.
// ----------------------------------------------------------------------------
module pes_result_checker #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic                          in_full,
  input  pes_pkg::pes_pixel_t           in_data,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  pes_pkg::pes_result_t          out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pes_pkg::CFG_W-1:0]     cfg_data,
  output int                            mismatches,
  output int                            beats_due
);
  import pes_pkg::*;

  // shadow registers and frame position
  logic [CFG_W-1:0]   frame_width;
  logic [CFG_W-1:0]   frame_height;
  int unsigned        col_count;
  int unsigned        row_count;

  // running extremes, one slot per statistic
  logic [VALUE_W-1:0] best_value [NUM_STATS];
  int unsigned        best_col   [NUM_STATS];
  int unsigned        best_row   [NUM_STATS];
  pes_pixel_t         best_pixel [NUM_STATS];
  bit                 seen       [NUM_STATS];

  // result beats predicted but not yet popped, oldest first
  pes_result_t        stats_due [$];

  // max trackers: brightest sum and largest of each component
  function automatic bit keeps_largest(input logic [STAT_W-1:0] id);
    case (id)
      STAT_MAX_SUM, STAT_MAX_R, STAT_MAX_G, STAT_MAX_B: return 1'b1;
      default:                                          return 1'b0;
    endcase
  endfunction

  // what a statistic compares: the component sum or one component
  function automatic logic [VALUE_W-1:0] stat_operand(input logic [STAT_W-1:0] id,
                                                      input pes_pixel_t pix);
    logic [VALUE_W-1:0] total;
    total = {2'b00, pix.red} + {2'b00, pix.green} + {2'b00, pix.blue};
    case (id)
      STAT_MAX_R, STAT_MIN_R: return {2'b00, pix.red};
      STAT_MAX_G, STAT_MIN_G: return {2'b00, pix.green};
      STAT_MAX_B, STAT_MIN_B: return {2'b00, pix.blue};
      default:                return total;
    endcase
  endfunction

  // zero acts as one, oversized values saturate at the maximum
  function automatic int unsigned clip_size(input logic [CFG_W-1:0] v, input int unsigned limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return v;
  endfunction

  function automatic void clear_trackers();
    foreach (seen[k]) seen[k] = 1'b0;
    col_count = 0;
    row_count = 0;
  endfunction

  // fold one accepted pixel into the extremes, queue results on frame end
  function automatic void track_pixel(input pes_pixel_t pix);
    logic [VALUE_W-1:0] v;
    logic [STAT_W-1:0]  id;
    bit                 frame_done;
    bit                 take;
    pes_result_t        beat;
    frame_done = 1'b0;
    for (int k = 0; k < NUM_STATS; k++) begin
      id = STAT_W'(k);
      v  = stat_operand(id, pix);
      // strict compare keeps the earliest pixel on ties
      if (!seen[k]) take = 1'b1;
      else if (keeps_largest(id)) take = (v > best_value[k]);
      else take = (v < best_value[k]);
      if (take) begin
        best_value[k] = v;
        best_col[k]   = col_count;
        best_row[k]   = row_count;
        best_pixel[k] = pix;
        seen[k]       = 1'b1;
      end
    end
    // raster advance against the geometry in force right now
    if (col_count + 1 >= clip_size(frame_width, MAX_WIDTH)) begin
      col_count = 0;
      if (row_count + 1 >= clip_size(frame_height, MAX_HEIGHT)) frame_done = 1'b1;
      else row_count++;
    end else begin
      col_count++;
    end
    if (frame_done) begin
      for (int k = 0; k < NUM_STATS; k++) begin
        beat.stat_id       = STAT_W'(k);
        beat.pos_x         = POS_W'(best_col[k]);
        beat.pos_y         = POS_W'(best_row[k]);
        beat.pixel_red     = best_pixel[k].red;
        beat.pixel_green   = best_pixel[k].green;
        beat.pixel_blue    = best_pixel[k].blue;
        beat.extreme_value = best_value[k];
        beat.last_of_run   = (k == NUM_STATS - 1);
        stats_due.push_back(beat);
      end
      clear_trackers();
    end
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // popped beat against the oldest prediction
  function automatic void check_beat(input pes_result_t got);
    pes_result_t want;
    if (stats_due.size() == 0) begin
      $error("result beat with no frame end pending: stat_id %0d", got.stat_id);
      mismatches++;
      return;
    end
    want = stats_due.pop_front();
    compare_field("stat_id",       want.stat_id,       got.stat_id);
    compare_field("pos_x",         want.pos_x,         got.pos_x);
    compare_field("pos_y",         want.pos_y,         got.pos_y);
    compare_field("pixel_red",     want.pixel_red,     got.pixel_red);
    compare_field("pixel_green",   want.pixel_green,   got.pixel_green);
    compare_field("pixel_blue",    want.pixel_blue,    got.pixel_blue);
    compare_field("extreme_value", want.extreme_value, got.extreme_value);
    compare_field("last_of_run",   want.last_of_run,   got.last_of_run);
  endfunction

  // sample all three channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_width  = FRAME_WIDTH_RST;
      frame_height = FRAME_HEIGHT_RST;
      clear_trackers();
      stats_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  = cfg_data;
          REG_FRAME_HEIGHT: frame_height = cfg_data;
          default: ;
        endcase
      end
      if (out_pop && !out_empty) check_beat(out_data);
      if (in_push && !in_full) track_pixel(in_data);
    end
    beats_due <= stats_due.size();
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for pixel_extreme_statistics_top
// Streams RGB pixels through frames of many geometries, including zero,
// oversized and mid-frame register changes, under random push and pop
// idling. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import pes_pkg::*;

  localparam int RESET_CYCLES = 8;
  // work queue settles well within this after the last beat is out
  localparam int DRAIN_CYCLES = 16;
  localparam int END_CYCLES   = 32;
  // longest quiet stretch of a correct run is a drain plus a few idle runs
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 160;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 2'd3;
  localparam logic [CFG_W-1:0]     SIZE_OVERSIZED  = 13'h1FFF;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  pes_pixel_t  in_data;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  pes_result_t out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int          mismatches;
  int          beats_due;
  int          quiet_cycles;
  int          push_idle_pct = 21;
  int          pop_idle_pct  = 66;
  pes_pixel_t  prev_pixel;

  pixel_extreme_statistics_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pes_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .beats_due  (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: pop at random per cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // watchdog on cycles with no beat accepted on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("pixel_extreme_statistics_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pes_pixel_t px(input logic [COLOUR_W-1:0] r, g, b);
    pes_pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    return p;
  endfunction

  // component biased toward the rails so ties and extremes show up often
  function automatic logic [COLOUR_W-1:0] rand_level();
    if ($urandom_range(4) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return COLOUR_W'($urandom);
  endfunction

  function automatic pes_pixel_t rand_pixel();
    pes_pixel_t p;
    // repeat the previous pixel now and then for exact ties
    if ($urandom_range(7) == 0) return prev_pixel;
    p = px(rand_level(), rand_level(), rand_level());
    prev_pixel = p;
    return p;
  endfunction

  // hold off pixels until every result is out and the work queue is empty
  task automatic wait_until_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (beats_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input pes_pixel_t pix);
    while ($urandom_range(99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= pix;
    do @(posedge clk); while (in_full);
  endtask

  // register beats back to back once the block is idle
  task automatic program_geometry(input logic [CFG_W-1:0] w, h, input bit poke_spare);
    logic [CFG_IDX_W-1:0] idx_list [$];
    logic [CFG_W-1:0]     val_list [$];
    wait_until_drained();
    idx_list.push_back(REG_FRAME_WIDTH);
    val_list.push_back(w);
    idx_list.push_back(REG_FRAME_HEIGHT);
    val_list.push_back(h);
    if (poke_spare) begin
      idx_list.push_back(REG_SPARE_FIRST);
      val_list.push_back(CFG_W'($urandom));
      idx_list.push_back(REG_SPARE_LAST);
      val_list.push_back('1);
    end
    foreach (idx_list[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // small random frames, sometimes left unfinished so the next geometry
  // lands in the middle of a frame
  task automatic random_frames(input int unsigned items);
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned count;
    sent = 0;
    while (sent < items) begin
      w = $urandom_range(8, 1);
      h = $urandom_range(6, 1);
      if ($urandom_range(9) == 0) w = 0;
      if ($urandom_range(9) == 0) h = 0;
      program_geometry(CFG_W'(w), CFG_W'(h), ($urandom_range(7) == 0));
      count = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * $urandom_range(3, 1);
      if ($urandom_range(5) == 0) count += $urandom_range(5, 1);
      repeat (count) send_pixel(rand_pixel());
      sent += count;
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    prev_pixel = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // zero geometry acts as one by one; spare indexes must not disturb it
    program_geometry('0, '0, 1'b1);
    send_pixel(px(8'h00, 8'h00, 8'h00));
    send_pixel(px(8'hFF, 8'hFF, 8'hFF));
    send_pixel(px(8'h80, 8'h40, 8'h01));

    // primaries and rails with ties, first in raster order wins
    program_geometry(13'd3, 13'd2, 1'b0);
    send_pixel(px(8'hFF, 8'h00, 8'h00));
    send_pixel(px(8'h00, 8'hFF, 8'h00));
    send_pixel(px(8'h00, 8'h00, 8'hFF));
    send_pixel(px(8'hFF, 8'hFF, 8'hFF));
    send_pixel(px(8'h00, 8'h00, 8'h00));
    send_pixel(px(8'hFF, 8'hFF, 8'hFF));

    // identical pixels, every tracker keeps the first
    program_geometry(13'd2, 13'd1, 1'b0);
    send_pixel(px(8'd37, 8'd200, 8'd91));
    send_pixel(px(8'd37, 8'd200, 8'd91));

    // geometry changes mid-frame: width shrinks past the column,
    // then goes oversized, then height drops to zero to close the frame
    program_geometry(13'd4, 13'd2, 1'b0);
    repeat (3) send_pixel(rand_pixel());
    program_geometry(13'd2, 13'd2, 1'b0);
    send_pixel(rand_pixel());
    program_geometry(SIZE_OVERSIZED, 13'd2, 1'b0);
    repeat (2) send_pixel(rand_pixel());
    program_geometry(13'd1, '0, 1'b0);
    send_pixel(rand_pixel());

    random_frames(PHASE_ITEMS);

    push_idle_pct = 66;
    pop_idle_pct  = 21;
    random_frames(PHASE_ITEMS);

    push_idle_pct = 0;
    pop_idle_pct  = 0;
    random_frames(PHASE_ITEMS);

    // one by one geometry closes whatever frame is open
    program_geometry(13'd1, 13'd1, 1'b0);
    send_pixel(rand_pixel());

    wait_until_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && beats_due == 0) begin
      $display("pixel_extreme_statistics_top test passed");
    end else begin
      $display("pixel_extreme_statistics_top test failed");
    end
    $finish;
  end

endmodule
